[src/slmb_pkg.sv]
package slmb_pkg;

    localparam int OP_W   = 2;
    localparam int MODE_W = 4;
    localparam int TICK_W = 6;

    typedef logic [TICK_W-1:0] t_tick;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_SET_MODE = 2'd1,
        OP_SET_MENU = 2'd2
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE_EMPTY     = 4'd0,
        MODE_IDLE_NOT_EMPTY = 4'd1,
        MODE_WAIT_MODEM     = 4'd2,
        MODE_BUTTON_MENU    = 4'd3,
        MODE_CONNECTING     = 4'd4,
        MODE_SMS_LISTEN     = 4'd5,
        MODE_SMS_PROC       = 4'd6,
        MODE_SENSOR_LEARN   = 4'd7,
        MODE_SENSOR_DELETE  = 4'd8,
        MODE_TRANSMIT       = 4'd9,
        MODE_NET_ERR        = 4'd10,
        MODE_RF_INT         = 4'd11
    } t_mode;

    localparam t_tick LED_ON_TICK   = 6'd1;
    localparam t_tick TX_OFF_TICK   = 6'd2;
    localparam t_tick NET_OFF_TICK  = 6'd4;
    localparam t_tick LED_OFF_TICK  = 6'd6;
    localparam t_tick PERIOD_SLOW   = 6'd15;
    localparam t_tick PERIOD_SENSOR = 6'd20;
    localparam t_tick RF_END_TICK   = 6'd21;
    localparam t_tick LIMIT_DEFAULT = 6'd20;
    localparam t_tick LIMIT_NET_ERR = 6'd47;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [MODE_W-1:0] new_mode;
        logic              menu_flag;
        logic              queue_empty;
        logic              transmit_enable;
    } t_item;

endpackage

[src/slmb_if.sv]
interface slmb_in_if;
    import slmb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [MODE_W-1:0] new_mode;
    logic              menu_flag;
    logic              queue_empty;
    logic              transmit_enable;

    modport source (
        output valid, operation, new_mode, menu_flag, queue_empty, transmit_enable,
        input  ready
    );
    modport sink (
        input  valid, operation, new_mode, menu_flag, queue_empty, transmit_enable,
        output ready
    );
endinterface

interface slmb_out_if;
    import slmb_pkg::*;

    logic              valid;
    logic              ready;
    logic              green_led_n;
    logic              blue_led_n;
    logic              sleep_allow;
    logic [MODE_W-1:0] current_mode;
    logic              in_menu;

    modport source (
        output valid, green_led_n, blue_led_n, sleep_allow, current_mode, in_menu,
        input  ready
    );
    modport sink (
        input  valid, green_led_n, blue_led_n, sleep_allow, current_mode, in_menu,
        output ready
    );
endinterface

[src/slmb_in_stage.sv]
module slmb_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slmb_in_if.sink         i_in,
    input  logic            i_take,
    output logic            o_vld,
    output slmb_pkg::t_item o_item
);
    import slmb_pkg::*;

    logic  r_vld;
    t_item r_item;

    assign i_in.ready = !r_vld || i_take;
    assign o_vld      = r_vld;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    // hold the beat until the core takes it
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.operation       <= i_in.operation;
            r_item.new_mode        <= i_in.new_mode;
            r_item.menu_flag       <= i_in.menu_flag;
            r_item.queue_empty     <= i_in.queue_empty;
            r_item.transmit_enable <= i_in.transmit_enable;
        end
    end

endmodule

[src/slmb_core.sv]
module slmb_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  slmb_pkg::t_item i_item,
    output logic            o_take,
    slmb_out_if.source      o_out
);
    import slmb_pkg::*;

    t_mode r_mode, n_mode;
    t_tick r_gt, n_gt;
    t_tick r_bt, n_bt;
    logic  r_g, n_g;
    logic  r_b, n_b;
    logic  r_sleep, n_sleep;
    logic  r_menu, n_menu;
    t_tick lim;
    logic  advance;

    logic              r_out_vld;
    logic              r_out_g;
    logic              r_out_b;
    logic              r_out_sleep;
    logic [MODE_W-1:0] r_out_mode;
    logic              r_out_menu;

    assign advance = !r_out_vld || o_out.ready;
    assign o_take  = i_vld && advance;

    always_comb begin
        n_mode  = r_mode;
        n_gt    = r_gt;
        n_bt    = r_bt;
        n_g     = r_g;
        n_b     = r_b;
        n_sleep = r_sleep;
        n_menu  = r_menu;
        lim     = LIMIT_DEFAULT;
        case (i_item.operation)
            OP_TICK: begin
                n_gt = r_gt + LED_ON_TICK;
                n_bt = r_bt + LED_ON_TICK;
                case (r_mode)
                    MODE_IDLE_EMPTY: begin
                        if (i_item.queue_empty && !r_menu) begin
                            n_g     = 1'b1;
                            n_b     = 1'b1;
                            n_sleep = 1'b1;
                        end else if (!r_menu) begin
                            n_mode  = MODE_IDLE_NOT_EMPTY;
                            n_sleep = 1'b0;
                        end else begin
                            n_mode  = MODE_BUTTON_MENU;
                            n_sleep = 1'b0;
                        end
                        n_gt = '0;
                        n_bt = '0;
                    end
                    MODE_IDLE_NOT_EMPTY, MODE_WAIT_MODEM, MODE_CONNECTING: begin
                        if (r_mode == MODE_IDLE_NOT_EMPTY) begin
                            n_sleep = 1'b0;
                        end
                        if (n_gt == LED_ON_TICK) begin
                            n_g = 1'b0;
                        end else if (n_gt == LED_OFF_TICK) begin
                            n_g = 1'b1;
                        end else if (n_gt == PERIOD_SLOW) begin
                            n_gt = '0;
                        end
                        n_b  = 1'b1;
                        n_bt = '0;
                    end
                    MODE_BUTTON_MENU: begin
                        if (i_item.transmit_enable) begin
                            n_menu = 1'b0;
                            n_mode = MODE_TRANSMIT;
                        end
                        if (n_gt == LED_ON_TICK) begin
                            n_g  = 1'b0;
                            n_b  = 1'b0;
                            n_gt = '0;
                            n_bt = '0;
                        end
                    end
                    MODE_SMS_LISTEN, MODE_SMS_PROC, MODE_SENSOR_LEARN: begin
                        n_g  = (r_mode != MODE_SENSOR_LEARN);
                        n_gt = '0;
                        if (n_bt == LED_ON_TICK) begin
                            n_b = 1'b0;
                        end else if (n_bt == LED_OFF_TICK) begin
                            n_b = 1'b1;
                        end else if ((r_mode == MODE_SENSOR_LEARN && n_bt == PERIOD_SENSOR) ||
                                     (r_mode != MODE_SENSOR_LEARN && n_bt == PERIOD_SLOW)) begin
                            n_bt = '0;
                        end
                    end
                    MODE_SENSOR_DELETE: begin
                        if (n_gt == LED_ON_TICK) begin
                            n_g = 1'b0;
                        end else if (n_gt == LED_OFF_TICK) begin
                            n_g = 1'b1;
                        end else if (n_gt == PERIOD_SENSOR) begin
                            n_gt = '0;
                        end
                        n_b  = 1'b0;
                        n_bt = '0;
                    end
                    MODE_TRANSMIT: begin
                        n_g  = 1'b1;
                        n_gt = '0;
                        if (n_bt == LED_ON_TICK) begin
                            n_b = 1'b0;
                        end else if (n_bt == TX_OFF_TICK) begin
                            n_b  = 1'b1;
                            n_bt = '0;
                        end
                    end
                    MODE_NET_ERR: begin
                        if (n_gt == LED_ON_TICK) begin
                            n_g = 1'b0;
                            n_b = 1'b0;
                        end else if (n_gt == NET_OFF_TICK) begin
                            n_g = 1'b1;
                            n_b = 1'b1;
                        end else if (n_gt == LIMIT_NET_ERR) begin
                            n_gt = '0;
                            n_bt = '0;
                        end
                    end
                    MODE_RF_INT: begin
                        if (n_gt == LED_ON_TICK) begin
                            n_g = 1'b0;
                        end else if (n_gt == RF_END_TICK) begin
                            n_g    = 1'b1;
                            n_gt   = '0;
                            n_mode = MODE_WAIT_MODEM;
                        end
                        n_b  = 1'b1;
                        n_bt = '0;
                    end
                    default: begin
                    end
                endcase
                // drop both counters once either passes the limit of the new mode
                if (n_mode == MODE_NET_ERR) begin
                    lim = LIMIT_NET_ERR;
                end
                if (n_gt > lim || n_bt > lim) begin
                    n_gt = '0;
                    n_bt = '0;
                end
            end
            OP_SET_MODE: begin
                if (i_item.new_mode <= MODE_RF_INT) begin
                    n_mode = t_mode'(i_item.new_mode);
                end
            end
            OP_SET_MENU: begin
                n_menu = i_item.menu_flag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE_EMPTY;
            r_gt      <= '0;
            r_bt      <= '0;
            r_g       <= 1'b1;
            r_b       <= 1'b1;
            r_sleep   <= 1'b0;
            r_menu    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_mode  <= n_mode;
                r_gt    <= n_gt;
                r_bt    <= n_bt;
                r_g     <= n_g;
                r_b     <= n_b;
                r_sleep <= n_sleep;
                r_menu  <= n_menu;
            end
            if (advance) begin
                r_out_vld <= i_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_g     <= n_g;
            r_out_b     <= n_b;
            r_out_sleep <= n_sleep;
            r_out_mode  <= n_mode;
            r_out_menu  <= n_menu;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.green_led_n  = r_out_g;
    assign o_out.blue_led_n   = r_out_b;
    assign o_out.sleep_allow  = r_out_sleep;
    assign o_out.current_mode = r_out_mode;
    assign o_out.in_menu      = r_out_menu;

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gt <= LIMIT_NET_ERR && r_bt <= LIMIT_NET_ERR)
        else $error("tick counter beyond limit");

    a_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.operation == OP_TICK) |=>
        (r_mode == MODE_NET_ERR || (r_gt <= LIMIT_DEFAULT && r_bt <= LIMIT_DEFAULT)))
        else $error("guard missed counters outside network-error mode");

    a_mode_keeps_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.operation == OP_SET_MODE) |=>
        ($stable(r_gt) && $stable(r_bt) && $stable(r_g) && $stable(r_b)))
        else $error("mode write touched counters or LEDs");

    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_out_vld && r_out_mode == r_mode && r_out_menu == r_menu
                    && r_out_g == r_g && r_out_b == r_b))
        else $error("result beat differs from state");

endmodule

[src/status_led_mode_blinker_top.sv]
// channel | dir | beat contents
// i_in    | in  | operation, new_mode, menu_flag, queue_empty, transmit_enable
// o_out   | out | green_led_n, blue_led_n, sleep_allow, current_mode, in_menu
//
// One beat in gives one beat out.
// A new beat is taken every cycle while o_out is not stalled: input register, mode/blink update, result register.
// Reset clears the mode to idle-empty, both counters to zero and both LEDs to dark.
// A stall on o_out holds the result; i_in keeps accepting until the input register is full.
module status_led_mode_blinker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slmb_in_if.sink    i_in,
    slmb_out_if.source o_out
);
    import slmb_pkg::*;

    logic  take;
    logic  item_vld;
    t_item item;

    slmb_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_vld   (item_vld),
        .o_item  (item)
    );

    slmb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (item_vld),
        .i_item  (item),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

[sim/slmb_checker.sv]
module slmb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    slmb_in_if   i_in_mon,
    slmb_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import slmb_pkg::*;

    typedef struct packed {
        logic              green_n;
        logic              blue_n;
        logic              sleep;
        logic [MODE_W-1:0] mode;
        logic              menu;
    } t_led_state;

    t_mode      mode_q;
    t_tick      green_cnt;
    t_tick      blue_cnt;
    logic       green_n;
    logic       blue_n;
    logic       sleep_ok;
    logic       menu_on;
    t_led_state led_state_q[$];
    int         mismatches;

    function automatic void blink(inout t_tick cnt, inout logic led_n, input t_tick period);
        if (cnt == LED_ON_TICK) begin
            led_n = 1'b0;
        end else if (cnt == LED_OFF_TICK) begin
            led_n = 1'b1;
        end else if (cnt == period) begin
            cnt = '0;
        end
    endfunction

    function automatic void advance_tick(logic q_empty, logic tx_en);
        t_tick lim;
        green_cnt = green_cnt + 1'b1;
        blue_cnt  = blue_cnt + 1'b1;
        case (mode_q)
            MODE_IDLE_EMPTY: begin
                if (q_empty && !menu_on) begin
                    green_n  = 1'b1;
                    blue_n   = 1'b1;
                    sleep_ok = 1'b1;
                end else if (!menu_on) begin
                    mode_q   = MODE_IDLE_NOT_EMPTY;
                    sleep_ok = 1'b0;
                end else begin
                    mode_q   = MODE_BUTTON_MENU;
                    sleep_ok = 1'b0;
                end
                green_cnt = '0;
                blue_cnt  = '0;
            end
            MODE_IDLE_NOT_EMPTY: begin
                sleep_ok = 1'b0;
                blink(green_cnt, green_n, PERIOD_SLOW);
                blue_n   = 1'b1;
                blue_cnt = '0;
            end
            MODE_WAIT_MODEM, MODE_CONNECTING: begin
                blink(green_cnt, green_n, PERIOD_SLOW);
                blue_n   = 1'b1;
                blue_cnt = '0;
            end
            MODE_BUTTON_MENU: begin
                if (tx_en) begin
                    menu_on = 1'b0;
                    mode_q  = MODE_TRANSMIT;
                end
                if (green_cnt == LED_ON_TICK) begin
                    green_n   = 1'b0;
                    blue_n    = 1'b0;
                    green_cnt = '0;
                    blue_cnt  = '0;
                end
            end
            MODE_SMS_LISTEN, MODE_SMS_PROC: begin
                green_n   = 1'b1;
                green_cnt = '0;
                blink(blue_cnt, blue_n, PERIOD_SLOW);
            end
            MODE_SENSOR_LEARN: begin
                green_n   = 1'b0;
                green_cnt = '0;
                blink(blue_cnt, blue_n, PERIOD_SENSOR);
            end
            MODE_SENSOR_DELETE: begin
                blink(green_cnt, green_n, PERIOD_SENSOR);
                blue_n   = 1'b0;
                blue_cnt = '0;
            end
            MODE_TRANSMIT: begin
                green_n   = 1'b1;
                green_cnt = '0;
                if (blue_cnt == LED_ON_TICK) begin
                    blue_n = 1'b0;
                end else if (blue_cnt == TX_OFF_TICK) begin
                    blue_n   = 1'b1;
                    blue_cnt = '0;
                end
            end
            MODE_NET_ERR: begin
                if (green_cnt == LED_ON_TICK) begin
                    green_n = 1'b0;
                    blue_n  = 1'b0;
                end else if (green_cnt == NET_OFF_TICK) begin
                    green_n = 1'b1;
                    blue_n  = 1'b1;
                end else if (green_cnt == LIMIT_NET_ERR) begin
                    green_cnt = '0;
                    blue_cnt  = '0;
                end
            end
            MODE_RF_INT: begin
                if (green_cnt == LED_ON_TICK) begin
                    green_n = 1'b0;
                end else if (green_cnt == RF_END_TICK) begin
                    green_n   = 1'b1;
                    green_cnt = '0;
                    mode_q    = MODE_WAIT_MODEM;
                end
                blue_n   = 1'b1;
                blue_cnt = '0;
            end
            default: begin
            end
        endcase
        lim = (mode_q == MODE_NET_ERR) ? LIMIT_NET_ERR : LIMIT_DEFAULT;
        if (green_cnt > lim || blue_cnt > lim) begin
            green_cnt = '0;
            blue_cnt  = '0;
        end
    endfunction

    function automatic t_led_state predict_leds(t_item it);
        t_led_state r;
        if (it.operation == OP_TICK) begin
            advance_tick(it.queue_empty, it.transmit_enable);
        end else if (it.operation == OP_SET_MODE) begin
            if (it.new_mode <= MODE_RF_INT) begin
                mode_q = t_mode'(it.new_mode);
            end
        end else if (it.operation == OP_SET_MENU) begin
            menu_on = it.menu_flag;
        end
        r.green_n = green_n;
        r.blue_n  = blue_n;
        r.sleep   = sleep_ok;
        r.mode    = mode_q;
        r.menu    = menu_on;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            if (mismatches < 10) begin
                $display("%s mismatch: expected %0d, actual %0d", name, want, got);
            end
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : p_check
        t_item      beat;
        t_led_state got;
        t_led_state want;
        if (!i_rst_n) begin
            mode_q     = MODE_IDLE_EMPTY;
            green_cnt  = '0;
            blue_cnt   = '0;
            green_n    = 1'b1;
            blue_n     = 1'b1;
            sleep_ok   = 1'b0;
            menu_on    = 1'b0;
            mismatches = 0;
            led_state_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.green_n = i_out_mon.green_led_n;
                got.blue_n  = i_out_mon.blue_led_n;
                got.sleep   = i_out_mon.sleep_allow;
                got.mode    = i_out_mon.current_mode;
                got.menu    = i_out_mon.in_menu;
                if (led_state_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result beat: mode %0d", got.mode);
                    end
                    mismatches++;
                end else begin
                    want = led_state_q.pop_front();
                    check_field("green_led_n", want.green_n, got.green_n);
                    check_field("blue_led_n", want.blue_n, got.blue_n);
                    check_field("sleep_allow", want.sleep, got.sleep);
                    check_field("current_mode", want.mode, got.mode);
                    check_field("in_menu", want.menu, got.menu);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                beat.operation       = i_in_mon.operation;
                beat.new_mode        = i_in_mon.new_mode;
                beat.menu_flag       = i_in_mon.menu_flag;
                beat.queue_empty     = i_in_mon.queue_empty;
                beat.transmit_enable = i_in_mon.transmit_enable;
                led_state_q.push_back(predict_leds(beat));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= led_state_q.size();
    end

endmodule

[sim/tb_status_led_mode_blinker_top.sv]
module tb_status_led_mode_blinker_top;
    import slmb_pkg::*;

    localparam int                N_ITEMS      = 1150;
    localparam int                HOLD_AFTER   = 300;
    localparam int                HOLD_CYCLES  = 250;
    localparam int                DRAIN_CYCLES = 8;
    localparam int                CYCLE_LIMIT  = 1000000;
    localparam logic [OP_W-1:0]   OP_UNUSED    = '1;
    localparam logic [MODE_W-1:0] MODE_MAX_RAW = '1;
    localparam logic [MODE_W-1:0] MODE_BAD_LOW = MODE_W'(MODE_RF_INT + 1);

    logic i_clk;
    logic i_rst_n;
    logic hold_on;
    logic tx_calm;
    int   fail_count;
    int   pending;
    int   n_sent;

    t_mode m_list[9] = '{MODE_IDLE_NOT_EMPTY, MODE_WAIT_MODEM, MODE_CONNECTING,
                         MODE_SMS_LISTEN, MODE_SMS_PROC, MODE_SENSOR_LEARN,
                         MODE_SENSOR_DELETE, MODE_NET_ERR, MODE_RF_INT};

    slmb_in_if  in_ch();
    slmb_out_if out_ch();

    status_led_mode_blinker_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    slmb_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic t_item rand_item();
        t_item r;
        r.operation       = OP_W'($urandom);
        r.new_mode        = MODE_W'($urandom);
        r.menu_flag       = 1'($urandom);
        r.queue_empty     = 1'($urandom);
        r.transmit_enable = 1'($urandom);
        return r;
    endfunction

    function automatic t_item mk(logic [OP_W-1:0] op, logic [MODE_W-1:0] nm,
                                 logic mf, logic qe, logic te);
        t_item r;
        r.operation       = op;
        r.new_mode        = nm;
        r.menu_flag       = mf;
        r.queue_empty     = qe;
        r.transmit_enable = te;
        return r;
    endfunction

    task automatic send_beat(t_item it);
        int gap;
        gap = (!tx_calm && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid           = 1'b1;
        in_ch.operation       = it.operation;
        in_ch.new_mode        = it.new_mode;
        in_ch.menu_flag       = it.menu_flag;
        in_ch.queue_empty     = it.queue_empty;
        in_ch.transmit_enable = it.transmit_enable;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (it.operation inside {OP_TICK, OP_SET_MENU}
            || (it.operation == OP_SET_MODE && it.new_mode <= MODE_RF_INT)) begin
            n_sent++;
        end
    endtask

    // receiver: random stalls, calm stretches, plus the long hold-off
    initial begin
        int   stall_left;
        int   cyc;
        logic rx_calm;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        cyc          = 0;
        rx_calm      = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 128 == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len();
            end
            out_ch.ready = !hold_on && (stall_left == 0);
        end
    end

    initial begin
        hold_on = 1'b0;
        wait (n_sent >= HOLD_AFTER);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status_led_mode_blinker_top test failed");
        $finish;
    end

    initial begin
        t_item it;
        int    r;
        int    run;
        int    m;
        in_ch.valid           = 1'b0;
        in_ch.operation       = OP_TICK;
        in_ch.new_mode        = MODE_IDLE_EMPTY;
        in_ch.menu_flag       = 1'b0;
        in_ch.queue_empty     = 1'b0;
        in_ch.transmit_enable = 1'b0;
        i_rst_n               = 1'b0;
        n_sent                = 0;
        tx_calm               = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: sleep entry, ignored items, menu round trip, every mode once
        send_beat(mk(OP_TICK, MODE_IDLE_EMPTY, 1'b0, 1'b1, 1'b0));
        send_beat(mk(OP_UNUSED, MODE_MAX_RAW, 1'b1, 1'b1, 1'b1));
        send_beat(mk(OP_SET_MODE, MODE_MAX_RAW, 1'b1, 1'b1, 1'b1));
        send_beat(mk(OP_SET_MODE, MODE_BAD_LOW, 1'b0, 1'b0, 1'b0));
        send_beat(mk(OP_SET_MENU, MODE_IDLE_EMPTY, 1'b1, 1'b0, 1'b0));
        send_beat(mk(OP_TICK, MODE_IDLE_EMPTY, 1'b0, 1'b1, 1'b0));
        send_beat(mk(OP_TICK, MODE_IDLE_EMPTY, 1'b0, 1'b1, 1'b0));
        send_beat(mk(OP_TICK, MODE_IDLE_EMPTY, 1'b0, 1'b0, 1'b1));
        foreach (m_list[i]) begin
            send_beat(mk(OP_SET_MODE, m_list[i], 1'b0, 1'b0, 1'b0));
            send_beat(mk(OP_TICK, MODE_IDLE_EMPTY, 1'b0, 1'b0, 1'b0));
        end
        send_beat(mk(OP_SET_MENU, MODE_IDLE_EMPTY, 1'b0, 1'b1, 1'b1));

        // random: mostly a mode write, then a run of mostly ticks, at times long enough to cross the periods
        while (n_sent < N_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_calm = ~tx_calm;
            end
            r  = $urandom_range(0, 99);
            it = rand_item();
            if (r < 80) begin
                it.operation = OP_SET_MODE;
                m            = $urandom_range(0, MODE_RF_INT);
                it.new_mode  = MODE_W'(m);
            end else if (r < 85) begin
                it.operation = OP_SET_MODE;
                m            = $urandom_range(MODE_BAD_LOW, MODE_MAX_RAW);
                it.new_mode  = MODE_W'(m);
            end else if (r < 95) begin
                it.operation = OP_SET_MENU;
            end else if (r < 97) begin
                it.operation = OP_UNUSED;
            end else begin
                it.operation = OP_TICK;
            end
            send_beat(it);
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
            repeat (run) begin
                it                 = rand_item();
                it.operation       = ($urandom_range(0, 31) == 0) ? OP_SET_MENU : OP_TICK;
                it.queue_empty     = ($urandom_range(0, 3) != 0);
                it.transmit_enable = ($urandom_range(0, 7) == 0);
                send_beat(it);
            end
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status_led_mode_blinker_top test passed");
        end else begin
            $display("status_led_mode_blinker_top test failed");
        end
        $finish;
    end

endmodule
